@@ rtl/pcdi_pkg.sv @@
// shared widths, status codes and the divider word for the depth interpolator
// no dependencies
package pcdi_pkg;

    localparam int COORD_BITS = 16;
    localparam int DEPTH_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int NUM_FIELDS = 11;
    localparam int IN_W       = FIELD_BITS * NUM_FIELDS;
    localparam int QW         = 32;
    localparam int FRAC       = 16;

    // widths of the exact integer terms
    localparam int DIFW = COORD_BITS + 1;
    localparam int PRW  = 2 * DIFW;
    localparam int DETW = PRW + 1;
    localparam int EW   = DETW + 2;
    localparam int ZZW  = 2 * DEPTH_BITS;
    localparam int NAW  = DETW + ZZW;
    localparam int NUMW = DETW + 3 * DEPTH_BITS;
    localparam int T1W  = EW + ZZW;
    localparam int DENW = T1W + 2;
    localparam int RW   = NUMW + FRAC;
    localparam int XW   = (RW > DENW + QW - 1) ? RW : DENW + QW - 1;

    // front pipeline depth
    localparam int NF = 8;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_NEG   = 2'd2,
        ST_OVF   = 2'd3
    } status_t;

    // word handed from cell to cell along the divider chain
    typedef struct packed {
        logic [XW-1:0] rem;
        logic [XW-1:0] dsh;
        logic [QW-1:0] q;
        status_t       status;
    } div_word_t;

endpackage

@@ rtl/pcdi_front.sv @@
// arithmetic front end: determinant, numerators, depth products, sign and range checks
// depends on pcdi_pkg
module pcdi_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  logic [pcdi_pkg::IN_W-1:0] in_data,
    output logic                  in_rdy,
    output logic                  out_vld,
    output pcdi_pkg::div_word_t   out_word,
    input  logic                  out_rdy
);
    import pcdi_pkg::*;

    logic [NF-1:0] ld;
    logic [NF-1:0] vld_reg;
    logic [NF-1:0] vld_next;

    // field unpacking
    logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, px, py;
    logic [DEPTH_BITS-1:0] za, zb, zc;

    assign ax = in_data[0*FIELD_BITS +: COORD_BITS];
    assign ay = in_data[1*FIELD_BITS +: COORD_BITS];
    assign za = in_data[2*FIELD_BITS +: DEPTH_BITS];
    assign bx = in_data[3*FIELD_BITS +: COORD_BITS];
    assign by = in_data[4*FIELD_BITS +: COORD_BITS];
    assign zb = in_data[5*FIELD_BITS +: DEPTH_BITS];
    assign cx = in_data[6*FIELD_BITS +: COORD_BITS];
    assign cy = in_data[7*FIELD_BITS +: COORD_BITS];
    assign zc = in_data[8*FIELD_BITS +: DEPTH_BITS];
    assign px = in_data[9*FIELD_BITS +: COORD_BITS];
    assign py = in_data[10*FIELD_BITS +: COORD_BITS];

    // stage load enables, a stage loads when empty or when the next one loads
    always_comb
    begin
        ld[NF-1] = !vld_reg[NF-1] || out_rdy;
        for (int k = NF - 2; k >= 0; k--)
        begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = ld[0] ? in_vld : vld_reg[0];
        for (int k = 1; k < NF; k++)
        begin
            vld_next[k] = ld[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_rdy  = ld[0];
    assign out_vld = vld_reg[NF-1];

    // stage 0: edge differences
    logic signed [DIFW-1:0] dbx_reg, dby_reg, dcx_reg, dcy_reg, dpx_reg, dpy_reg;
    logic [DEPTH_BITS-1:0] za0_reg, zb0_reg, zc0_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            dbx_reg <= DIFW'(bx) - DIFW'(ax);
            dby_reg <= DIFW'(by) - DIFW'(ay);
            dcx_reg <= DIFW'(cx) - DIFW'(ax);
            dcy_reg <= DIFW'(cy) - DIFW'(ay);
            dpx_reg <= DIFW'(px) - DIFW'(ax);
            dpy_reg <= DIFW'(py) - DIFW'(ay);
            za0_reg <= za;
            zb0_reg <= zb;
            zc0_reg <= zc;
        end
    end

    // stage 1: cross products
    logic signed [PRW-1:0] p_bycx_reg, p_bxcy_reg, p_pycx_reg, p_pxcy_reg;
    logic signed [PRW-1:0] p_pybx_reg, p_pxby_reg;
    logic [DEPTH_BITS-1:0] za1_reg, zb1_reg, zc1_reg;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            p_bycx_reg <= PRW'(dby_reg) * PRW'(dcx_reg);
            p_bxcy_reg <= PRW'(dbx_reg) * PRW'(dcy_reg);
            p_pycx_reg <= PRW'(dpy_reg) * PRW'(dcx_reg);
            p_pxcy_reg <= PRW'(dpx_reg) * PRW'(dcy_reg);
            p_pybx_reg <= PRW'(dpy_reg) * PRW'(dbx_reg);
            p_pxby_reg <= PRW'(dpx_reg) * PRW'(dby_reg);
            za1_reg    <= za0_reg;
            zb1_reg    <= zb0_reg;
            zc1_reg    <= zc0_reg;
        end
    end

    // stage 2: determinant, numerators, depth pair products
    logic signed [DETW-1:0] det2_reg, nb2_reg, ng2_reg;
    logic [ZZW-1:0] zab2_reg, zac2_reg, zbc2_reg;
    logic [DEPTH_BITS-1:0] zc2_reg;
    logic zbad2_reg;

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            det2_reg  <= DETW'(p_bycx_reg) - DETW'(p_bxcy_reg);
            nb2_reg   <= DETW'(p_pycx_reg) - DETW'(p_pxcy_reg);
            ng2_reg   <= DETW'(p_pybx_reg) - DETW'(p_pxby_reg);
            zab2_reg  <= ZZW'(za1_reg) * ZZW'(zb1_reg);
            zac2_reg  <= ZZW'(za1_reg) * ZZW'(zc1_reg);
            zbc2_reg  <= ZZW'(zb1_reg) * ZZW'(zc1_reg);
            zc2_reg   <= zc1_reg;
            zbad2_reg <= (za1_reg == '0) || (zb1_reg == '0) || (zc1_reg == '0);
        end
    end

    // stage 3: alpha numerator and first depth products
    logic signed [EW-1:0] e3_reg;
    logic signed [NAW-1:0] numa3_reg, nbz3_reg, ngz3_reg;
    logic [ZZW-1:0] zbc3_reg;
    logic [DEPTH_BITS-1:0] zc3_reg;
    logic degen3_reg;

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            e3_reg     <= EW'(det2_reg) - EW'(nb2_reg) + EW'(ng2_reg);
            numa3_reg  <= NAW'(det2_reg) * $signed(NAW'(zab2_reg));
            nbz3_reg   <= NAW'(nb2_reg) * $signed(NAW'(zac2_reg));
            ngz3_reg   <= NAW'(ng2_reg) * $signed(NAW'(zab2_reg));
            zbc3_reg   <= zbc2_reg;
            zc3_reg    <= zc2_reg;
            degen3_reg <= zbad2_reg || (det2_reg == '0);
        end
    end

    // stage 4: full numerator and alpha term
    logic signed [NUMW-1:0] num4_reg;
    logic signed [T1W-1:0] t14_reg;
    logic signed [NAW-1:0] nbz4_reg, ngz4_reg;
    logic degen4_reg;

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            num4_reg   <= NUMW'(numa3_reg) * $signed(NUMW'(zc3_reg));
            t14_reg    <= T1W'(e3_reg) * $signed(T1W'(zbc3_reg));
            nbz4_reg   <= nbz3_reg;
            ngz4_reg   <= ngz3_reg;
            degen4_reg <= degen3_reg;
        end
    end

    // stage 5: denominator
    logic signed [NUMW-1:0] num5_reg;
    logic signed [DENW-1:0] den5_reg;
    logic degen5_reg;

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            num5_reg   <= num4_reg;
            den5_reg   <= DENW'(t14_reg) + DENW'(nbz4_reg) - DENW'(ngz4_reg);
            degen5_reg <= degen4_reg;
        end
    end

    // stage 6: status from zero and sign tests, magnitudes
    logic [NUMW-1:0] nmag6_reg;
    logic [DENW-1:0] dmag6_reg;
    status_t st6_reg;
    status_t st6_next;

    always_comb
    begin
        if (degen5_reg || (den5_reg == '0))
        begin
            st6_next = ST_DEGEN;
        end
        else if (num5_reg[NUMW-1] != den5_reg[DENW-1])
        begin
            st6_next = ST_NEG;
        end
        else
        begin
            st6_next = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[6])
        begin
            nmag6_reg <= num5_reg[NUMW-1] ? NUMW'(-num5_reg) : NUMW'(num5_reg);
            dmag6_reg <= den5_reg[DENW-1] ? DENW'(-den5_reg) : DENW'(den5_reg);
            st6_reg   <= st6_next;
        end
    end

    // stage 7: scaled remainder, overflow test, divisor aligned to the top bit
    logic [XW-1:0] rem_next;
    logic [XW:0] lim_next;
    div_word_t word_reg;
    div_word_t word_next;

    always_comb
    begin
        rem_next         = XW'(nmag6_reg) << FRAC;
        lim_next         = (XW+1)'(dmag6_reg) << QW;
        word_next.rem    = rem_next;
        word_next.dsh    = XW'(dmag6_reg) << (QW - 1);
        word_next.q      = '0;
        word_next.status = st6_reg;
        if ((st6_reg == ST_OK) && ({1'b0, rem_next} >= lim_next))
        begin
            word_next.status = ST_OVF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[7])
        begin
            word_reg <= word_next;
        end
    end

    assign out_word = word_reg;

endmodule

@@ rtl/pcdi_div_cell.sv @@
// one restoring division cell: settles one quotient bit and hands the word on
// depends on pcdi_pkg
module pcdi_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  pcdi_pkg::div_word_t in_word,
    output logic                in_rdy,
    output logic                out_vld,
    output pcdi_pkg::div_word_t out_word,
    input  logic                out_rdy
);
    import pcdi_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    div_word_t word_reg;
    div_word_t word_next;
    logic      ge;

    assign in_rdy = !vld_reg || out_rdy;

    // trial subtract of the aligned divisor
    always_comb
    begin
        ge               = (in_word.rem >= in_word.dsh);
        word_next.rem    = ge ? (in_word.rem - in_word.dsh) : in_word.rem;
        word_next.dsh    = in_word.dsh >> 1;
        word_next.q      = {in_word.q[QW-2:0], ge};
        word_next.status = in_word.status;
        vld_next         = in_rdy ? in_vld : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy)
        begin
            word_reg <= word_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_word = word_reg;

endmodule

@@ rtl/perspective_correct_depth_interp_top.sv @@
// perspective-correct depth interpolation, top level
// depends on pcdi_pkg, pcdi_front, pcdi_div_cell
//
//  channel   dir  tdata                                          tuser
//  s_axis    in   a_x a_y a_z b_x b_y b_z c_x c_y c_z p_x p_y    -
//  m_axis    out  depth (Q16.16)                                 status
//
// one word accepted per cycle unless a stalled output backs the chain up;
// 8 front stages, 32 divider cells (one quotient bit each), output reg.
// reset clears only the valid bits; there is no clearing pass.
// a stalled output only holds words that cannot move; empty stages keep
// filling, so input is taken while a result waits.
module perspective_correct_depth_interp_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y (16 bits each)
    input  logic [pcdi_pkg::IN_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // depth [31:0]
    output logic [pcdi_pkg::QW-1:0]   m_axis_tdata,
    // status [1:0]
    output logic [1:0]                m_axis_tuser
);
    import pcdi_pkg::*;

    logic      vld_chain [QW+1];
    logic      rdy_chain [QW+1];
    div_word_t word_chain [QW+1];

    // front arithmetic
    pcdi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .in_rdy   (s_axis_tready),
        .out_vld  (vld_chain[0]),
        .out_word (word_chain[0]),
        .out_rdy  (rdy_chain[0])
    );

    // divider chain
    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        pcdi_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (vld_chain[i]),
            .in_word  (word_chain[i]),
            .in_rdy   (rdy_chain[i]),
            .out_vld  (vld_chain[i+1]),
            .out_word (word_chain[i+1]),
            .out_rdy  (rdy_chain[i+1])
        );
    end

    // output register with final depth select
    logic          out_vld_reg;
    logic          out_vld_next;
    logic [QW-1:0] depth_reg;
    logic [QW-1:0] depth_next;
    status_t       status_reg;

    assign rdy_chain[QW] = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        out_vld_next = rdy_chain[QW] ? vld_chain[QW] : out_vld_reg;
        case (word_chain[QW].status)
            ST_OK:   depth_next = word_chain[QW].q;
            ST_OVF:  depth_next = '1;
            default: depth_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_chain[QW])
        begin
            depth_reg  <= depth_next;
            status_reg <= word_chain[QW].status;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = depth_reg;
    assign m_axis_tuser  = status_reg;

    // saturated results carry all ones
    a_ovf_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_OVF)) |-> (m_axis_tdata == '1))
        else $error("overflow word without saturated depth");

    // degenerate and negative results carry zero depth
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((m_axis_tuser == ST_DEGEN) || (m_axis_tuser == ST_NEG)))
        |-> (m_axis_tdata == '0))
        else $error("degenerate or negative word with nonzero depth");

    // a word waiting in the last cell moves once the output frees up
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_chain[QW] && !out_vld_reg) |=> out_vld_reg)
        else $error("divider output not taken into free output register");

endmodule

@@ test/perspective_correct_depth_interp_checker.sv @@
// checker for the depth interpolator: watches both channels, predicts each result
// and compares it; depends on pcdi_pkg
module perspective_correct_depth_interp_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [pcdi_pkg::IN_W-1:0] s_axis_tdata,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [pcdi_pkg::QW-1:0]   m_axis_tdata,
    input  logic [1:0]                m_axis_tuser,
    output int                        errors,
    output int                        pending
);
    import pcdi_pkg::*;

    typedef struct packed {
        logic [31:0] depth;
        status_t     status;
    } depth_res_t;

    depth_res_t depth_q[$];

    // exact rational depth for one triangle and point
    function automatic depth_res_t interp_depth(input logic [IN_W-1:0] w);
        logic signed [63:0] ax, ay, bx, by, cx, cy, px, py;
        logic [63:0] za, zb, zc;
        logic signed [63:0] det, nb, ng, e;
        logic signed [255:0] num, den;
        logic [255:0] an, ad, rem;
        depth_res_t r;
        ax = 64'(signed'(w[15:0]));    ay = 64'(signed'(w[31:16]));
        za = 64'(w[47:32]);
        bx = 64'(signed'(w[63:48]));   by = 64'(signed'(w[79:64]));
        zb = 64'(w[95:80]);
        cx = 64'(signed'(w[111:96]));  cy = 64'(signed'(w[127:112]));
        zc = 64'(w[143:128]);
        px = 64'(signed'(w[159:144])); py = 64'(signed'(w[175:160]));
        det = (by-ay)*(cx-ax) - (bx-ax)*(cy-ay);
        nb = (py-ay)*(cx-ax) - (px-ax)*(cy-ay);
        ng = (py-ay)*(bx-ax) - (px-ax)*(by-ay);
        e = det - nb + ng;
        r = '0;
        if (det == 0 || za == 0 || zb == 0 || zc == 0) begin
            r.status = ST_DEGEN;
            return r;
        end
        num = 256'(det) * $signed({1'b0, za}) * $signed({1'b0, zb}) * $signed({1'b0, zc});
        den = 256'(e) * $signed({1'b0, zb}) * $signed({1'b0, zc})
            + 256'(nb) * $signed({1'b0, za}) * $signed({1'b0, zc})
            - 256'(ng) * $signed({1'b0, za}) * $signed({1'b0, zb});
        if (den == 0) begin
            r.status = ST_DEGEN;
        end
        else if (num[255] != den[255]) begin
            r.status = ST_NEG;
        end
        else begin
            an = num[255] ? -num : num;
            ad = den[255] ? -den : den;
            rem = (an << 16) / ad;
            if (rem >= (256'd1 << 32)) begin
                r.depth = 32'hFFFF_FFFF;
                r.status = ST_OVF;
            end
            else begin
                r.depth = rem[31:0];
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    assign pending = depth_q.size();

    // predict on input words, compare on output words
    always @(posedge clk or negedge rst_n)
    begin
        depth_res_t exp_r;
        if (!rst_n)
        begin
            errors <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                depth_q.push_back(interp_depth(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (depth_q.size() == 0)
                begin
                    $display("%0t: unexpected word depth=%h status=%0d", $time,
                             m_axis_tdata, m_axis_tuser);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = depth_q.pop_front();
                    if (exp_r.depth !== m_axis_tdata || exp_r.status !== m_axis_tuser)
                    begin
                        $display("%0t: mismatch expected depth=%h status=%0d actual depth=%h status=%0d",
                                 $time, exp_r.depth, exp_r.status, m_axis_tdata, m_axis_tuser);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ test/perspective_correct_depth_interp_top_tb.sv @@
// stimulus and verdict for the depth interpolator
// depends on pcdi_pkg, perspective_correct_depth_interp_top and the checker
module perspective_correct_depth_interp_top_tb;
    import pcdi_pkg::*;

    logic            clk = 0;
    logic            rst_n = 0;
    logic            s_axis_tvalid = 0;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 0;
    logic [QW-1:0]   m_axis_tdata;
    logic [1:0]      m_axis_tuser;
    int              errors, pending;
    logic            calm = 0;
    logic            hold_off = 0;
    int              idle_cnt = 0;

    always #5 clk = ~clk;

    perspective_correct_depth_interp_top dut (.*);
    perspective_correct_depth_interp_checker chk (.*);

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 5000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver with random stalls, a calm stretch and a long hold-off
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            m_axis_tready <= 0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 37);
    end

    initial
    begin
        repeat (400) @(posedge clk);
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
    end

    function automatic logic [15:0] coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(200)) - 16'd100;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] zval();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] pack(input logic [15:0] f [11]);
        logic [IN_W-1:0] w;
        for (int i = 0; i < 11; i++)
            w[i*16 +: 16] = f[i];
        return w;
    endfunction

    task automatic send_word(input logic [IN_W-1:0] w);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= w;
        do @(posedge clk); while (!s_axis_tready);
        if (!calm && $urandom_range(99) < 37)
        begin
            s_axis_tvalid <= 0;
            do @(posedge clk); while ($urandom_range(99) < 37);
        end
    endtask

    task automatic send_tri(input int ax, ay, za, bx, by, zb, cx, cy, zc, px, py);
        logic [15:0] f [11];
        f = '{16'(ax), 16'(ay), 16'(za), 16'(bx), 16'(by), 16'(zb),
              16'(cx), 16'(cy), 16'(zc), 16'(px), 16'(py)};
        send_word(pack(f));
    endtask

    initial
    begin
        logic [15:0] f [11];
        int wait_cnt;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: ordinary, at vertices, degenerate, negative, overflow, extremes
        send_tri(0, 0, 100, 0, 10, 200, 10, 0, 300, 3, 3);
        send_tri(0, 0, 100, 0, 10, 200, 10, 0, 300, 0, 0);
        send_tri(0, 0, 100, 0, 10, 200, 10, 0, 300, 10, 0);
        send_tri(0, 0, 100, 5, 5, 200, 10, 10, 300, 3, 3);
        send_tri(0, 0, 0, 0, 10, 200, 10, 0, 300, 3, 3);
        send_tri(0, 0, 100, 0, 10, 0, 10, 0, 300, 3, 3);
        send_tri(0, 0, 100, 0, 10, 200, 10, 0, 0, 3, 3);
        send_tri(0, 0, 1, 0, 10, 65535, 10, 0, 65535, 100, 100);
        send_tri(0, 0, 65535, 0, 10, 65535, 10, 0, 65535, 2, 2);
        send_tri(0, 0, 1, 0, 2, 1, 2, 0, 3, -30000, 20000);
        send_tri(0, 0, 65535, 0, 1, 65535, 1, 0, 65535, 0, 0);
        send_tri(-32768, -32768, 65535, 32767, -32768, 1, -32768, 32767, 65535,
                 32767, 32767);
        send_tri(32767, 32767, 1, -32768, 32767, 65535, 32767, -32768, 1,
                 -32768, -32768);
        send_tri(0, 0, 10, 0, 4, 20, 4, 0, 30, 100, -50);
        send_tri(0, 0, 1, 0, 4, 3, 4, 0, 1, 4, 4);
        for (int k = 0; k < 650; k++)
        begin
            calm = (k >= 200 && k < 300);
            if ($urandom_range(3) == 0)
            begin
                for (int i = 0; i < 11; i++)
                    f[i] = (i % 3 == 2 && i < 9) ? zval() : coord();
            end
            else
            begin
                // well-formed small triangle near a random origin, point near it
                f[0] = 16'($urandom_range(2000)) - 16'd1000;
                f[1] = 16'($urandom_range(2000)) - 16'd1000;
                f[3] = f[0] + 16'($urandom_range(400)) - 16'd200;
                f[4] = f[1] + 16'($urandom_range(400)) - 16'd200;
                f[6] = f[0] + 16'($urandom_range(400)) - 16'd200;
                f[7] = f[1] + 16'($urandom_range(400)) - 16'd200;
                f[9] = f[0] + 16'($urandom_range(500)) - 16'd250;
                f[10] = f[1] + 16'($urandom_range(500)) - 16'd250;
                f[2] = 16'($urandom_range(65535, 1));
                f[5] = 16'($urandom_range(65535, 1));
                f[8] = 16'($urandom_range(65535, 1));
            end
            send_word(pack(f));
        end
        calm = 0;
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge clk);
        wait_cnt = 0;
        while (wait_cnt < 60)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
